// ===== rtl/csvft_pkg.sv =====
`timescale 1ns / 1ps

package csvft_pkg;

    localparam int CH_W    = 8;
    localparam int FIDX_W  = 11;
    localparam int OFS_W   = 16;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 64;

    // parse phases within one line
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PLAIN  = 3'd1,
        PH_QUOTED = 3'd2,
        PH_QSEEN  = 3'd3,
        PH_ERROR  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FIELD = 2'd0,
        KIND_OK    = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_QUOTE    = 2'd1,
        ERR_MISSING  = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    typedef enum logic [CFGI_W-1:0] {
        CFG_SEPARATOR  = 2'd0,
        CFG_QUOTE      = 2'd1,
        CFG_SELECT_ALL = 2'd2,
        CFG_MASK       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            line_end;
    } t_in_word;

    typedef struct packed {
        t_kind             kind;
        logic [FIDX_W-1:0] field_index;
        logic [OFS_W-1:0]  start_offset;
        logic [OFS_W-1:0]  length;
        t_err              error_code;
        logic              last;
    } t_out_word;

    // up to two records per byte; second valid implies first valid
    typedef struct packed {
        logic      v0;
        t_out_word w0;
        logic      v1;
        t_out_word w1;
    } t_res_pair;

    typedef struct packed {
        logic [CH_W-1:0] separator_char;
        logic [CH_W-1:0] quote_char;
        logic            select_all;
    } t_cfg;

endpackage

// ===== rtl/csv_field_tokenizer.sv =====
`timescale 1ns / 1ps

// csv_field_tokenizer: streaming CSV tokenizer taking one byte of a line per
// input word and returning field records (index, start offset after any opening
// quote, raw length) followed by one summary record per line (ok, bad quote,
// missing field or overflow). A byte is parsed in the cycle it is accepted, so
// one word can be taken every clock while the queue has room. Records drain at one
// per cycle, while the receiver is ready, from a four-entry output queue; input stalls
// only when fewer than two queue slots are free, so that a byte that closes a field at
// line end can always place both its records. Configuration writes take effect on
// the next cycle and should be issued only between lines while no records are pending.

module csv_field_tokenizer #(
    parameter int MAX_LINE_BYTES = 65536,
    parameter int MASK_COLUMNS   = 64,
    parameter int MAX_FIELDS     = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // byte stream
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  csvft_pkg::t_in_word                  i_in_word,
    // record stream
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output csvft_pkg::t_out_word                 o_out_word,
    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [csvft_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [csvft_pkg::CFGD_W-1:0]         i_cfg_data
);
    import csvft_pkg::*;

    t_cfg                     r_cfg;
    logic [MASK_COLUMNS-1:0]  r_column_mask;
    t_res_pair                res;
    logic                     room;
    logic                     take;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator_char <= 8'd44;
            r_cfg.quote_char     <= 8'd34;
            r_cfg.select_all     <= 1'b1;
            r_column_mask        <= '1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SEPARATOR:  r_cfg.separator_char <= i_cfg_data[CH_W-1:0];
                CFG_QUOTE:      r_cfg.quote_char     <= i_cfg_data[CH_W-1:0];
                CFG_SELECT_ALL: r_cfg.select_all     <= i_cfg_data[0];
                CFG_MASK:       r_column_mask        <= i_cfg_data[MASK_COLUMNS-1:0];
                default: ;
            endcase
        end
    end

    // input word accepted when the queue can hold a full pair of records
    assign o_in_ready = room;
    assign take       = i_in_valid && room;

    csvft_parse #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MASK_COLUMNS   (MASK_COLUMNS),
        .MAX_FIELDS     (MAX_FIELDS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (i_in_word),
        .i_cfg   (r_cfg),
        .i_mask  (r_column_mask),
        .o_res   (res)
    );

    // result queue doubles as the output register
    csvft_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

// ===== rtl/csvft_parse.sv =====
`timescale 1ns / 1ps

module csvft_parse #(
    parameter int MAX_LINE_BYTES = 65536,
    parameter int MASK_COLUMNS   = 64,
    parameter int MAX_FIELDS     = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  csvft_pkg::t_in_word       i_word,
    input  csvft_pkg::t_cfg           i_cfg,
    input  logic [MASK_COLUMNS-1:0]   i_mask,
    output csvft_pkg::t_res_pair      o_res
);
    import csvft_pkg::*;

    localparam int OW = $clog2(MAX_LINE_BYTES + 1);
    localparam int FW = $clog2(MAX_FIELDS + 1);
    localparam int CW = $clog2(MASK_COLUMNS);

    t_phase            r_phase, n_phase;
    logic [OW-1:0]     r_byte_offset, n_byte_offset;
    logic [FW-1:0]     r_field_count, n_field_count;
    logic [OFS_W-1:0]  r_field_start, n_field_start;
    t_err              r_pending_error, n_pending_error;
    logic [FW-1:0]     r_error_field, n_error_field;

    logic              is_end;
    logic              act_cur;
    logic              act_next;
    logic              do_fin;
    logic [OW-1:0]     fin_end;
    logic              raise_q;
    logic              raise_ovf;
    logic              fc_full;
    t_out_word         rec_field;
    logic              rec_field_v;
    t_out_word         rec_final;

    // some selected column at or beyond fc remains
    function automatic logic active(input logic [FW-1:0] fc, input logic sel_all,
                                    input logic [MASK_COLUMNS-1:0] mask);
        logic [MASK_COLUMNS-1:0] ge;
        logic [CW-1:0]           idx;
        idx = fc[CW-1:0];
        for (int i = 0; i < MASK_COLUMNS; i++) begin
            ge[i] = (i >= int'(idx));
        end
        return sel_all || ((fc < FW'(MASK_COLUMNS)) && (|(mask & ge)));
    endfunction

    function automatic logic selected(input logic [FW-1:0] fc, input logic sel_all,
                                      input logic [MASK_COLUMNS-1:0] mask);
        logic [CW-1:0] idx;
        idx = fc[CW-1:0];
        return sel_all || ((fc < FW'(MASK_COLUMNS)) && mask[idx]);
    endfunction

    assign is_end   = i_word.line_end || (i_word.ch == '0);
    assign act_cur  = active(r_field_count, i_cfg.select_all, i_mask);
    assign fc_full  = (r_field_count >= FW'(MAX_FIELDS));

    always_comb begin
        n_phase         = r_phase;
        n_byte_offset   = r_byte_offset;
        n_field_count   = r_field_count;
        n_field_start   = r_field_start;
        n_pending_error = r_pending_error;
        n_error_field   = r_error_field;
        do_fin          = 1'b0;
        fin_end         = r_byte_offset;
        raise_q         = 1'b0;
        raise_ovf       = 1'b0;
        rec_field_v     = 1'b0;
        rec_field       = '0;

        if (i_take && (r_phase != PH_ERROR) && act_cur) begin
            if (!is_end) begin
                if (r_byte_offset >= OW'(MAX_LINE_BYTES)) begin
                    raise_ovf = 1'b1;
                end else begin
                    n_byte_offset = r_byte_offset + 1'b1;
                    unique case (r_phase)
                        PH_START: begin
                            if (i_word.ch == i_cfg.quote_char) begin
                                n_field_start = OFS_W'(r_byte_offset) + 1'b1;
                                n_phase       = PH_QUOTED;
                            end else if (i_word.ch == i_cfg.separator_char) begin
                                n_field_start = OFS_W'(r_byte_offset);
                                do_fin        = 1'b1;
                            end else begin
                                n_field_start = OFS_W'(r_byte_offset);
                                n_phase       = PH_PLAIN;
                            end
                        end
                        PH_PLAIN: begin
                            if (i_word.ch == i_cfg.separator_char) do_fin = 1'b1;
                        end
                        PH_QUOTED: begin
                            if (i_word.ch == i_cfg.quote_char) n_phase = PH_QSEEN;
                        end
                        PH_QSEEN: begin
                            if (i_word.ch == i_cfg.quote_char) begin
                                n_phase = PH_QUOTED;
                            end else if (i_word.ch == i_cfg.separator_char) begin
                                do_fin  = 1'b1;
                                fin_end = r_byte_offset - 1'b1;
                            end else begin
                                raise_q = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end else begin
                unique case (r_phase)
                    PH_PLAIN:  do_fin = 1'b1;
                    PH_QSEEN: begin
                        do_fin  = 1'b1;
                        fin_end = r_byte_offset - 1'b1;
                    end
                    PH_QUOTED: raise_q = 1'b1;
                    default: ;
                endcase
            end
        end

        // close the current field
        if (do_fin) begin
            if (fc_full) begin
                raise_ovf = 1'b1;
            end else begin
                if (selected(r_field_count, i_cfg.select_all, i_mask)) begin
                    rec_field_v              = 1'b1;
                    rec_field.kind           = KIND_FIELD;
                    rec_field.field_index    = FIDX_W'(r_field_count);
                    rec_field.start_offset   = n_field_start;
                    rec_field.length         = OFS_W'(fin_end) - n_field_start;
                    rec_field.error_code     = ERR_NONE;
                    rec_field.last           = 1'b0;
                end
                n_field_count = r_field_count + 1'b1;
                n_phase       = PH_START;
            end
        end

        if (raise_q || raise_ovf) begin
            n_pending_error = raise_q ? ERR_QUOTE : ERR_OVERFLOW;
            n_error_field   = r_field_count;
            n_phase         = PH_ERROR;
        end
    end

    assign act_next = active(n_field_count, i_cfg.select_all, i_mask);

    // line summary record
    always_comb begin
        rec_final.start_offset = '0;
        rec_final.length       = OFS_W'(r_byte_offset);
        rec_final.last         = 1'b1;
        if (n_pending_error != ERR_NONE) begin
            rec_final.kind        = KIND_ERROR;
            rec_final.field_index = FIDX_W'(n_error_field);
            rec_final.error_code  = n_pending_error;
        end else if (!i_cfg.select_all && act_next) begin
            rec_final.kind        = KIND_ERROR;
            rec_final.field_index = FIDX_W'(n_field_count);
            rec_final.error_code  = ERR_MISSING;
        end else begin
            rec_final.kind        = KIND_OK;
            rec_final.field_index = FIDX_W'(n_field_count);
            rec_final.error_code  = ERR_NONE;
        end
    end

    always_comb begin
        o_res = '0;
        if (rec_field_v) begin
            o_res.v0 = 1'b1;
            o_res.w0 = rec_field;
            if (i_take && is_end) begin
                o_res.v1 = 1'b1;
                o_res.w1 = rec_final;
            end
        end else if (i_take && is_end) begin
            o_res.v0 = 1'b1;
            o_res.w0 = rec_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START;
            r_byte_offset   <= '0;
            r_field_count   <= '0;
            r_field_start   <= '0;
            r_pending_error <= ERR_NONE;
            r_error_field   <= '0;
        end else if (i_take && is_end) begin
            r_phase         <= PH_START;
            r_byte_offset   <= '0;
            r_field_count   <= '0;
            r_field_start   <= '0;
            r_pending_error <= ERR_NONE;
            r_error_field   <= '0;
        end else if (i_take) begin
            r_phase         <= n_phase;
            r_byte_offset   <= n_byte_offset;
            r_field_count   <= n_field_count;
            r_field_start   <= n_field_start;
            r_pending_error <= n_pending_error;
            r_error_field   <= n_error_field;
        end
    end

endmodule

// ===== rtl/csvft_outq.sv =====
`timescale 1ns / 1ps

module csvft_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csvft_pkg::t_res_pair  i_res,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_ready,
    output csvft_pkg::t_out_word  o_word
);
    import csvft_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_out_word          r_mem [DEPTH];
    logic [PW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [PW:0]        r_count, n_count;
    logic               pop;
    logic [PW-1:0]      wr_ptr1;

    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    // room for the two records one byte can cause
    assign o_room  = (r_count <= (PW+1)'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + (PW)'(i_res.v0) + (PW)'(i_res.v1);
        n_rd_ptr = r_rd_ptr + (PW)'(pop);
        n_count  = r_count + (PW+1)'(i_res.v0) + (PW+1)'(i_res.v1) - (PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.v0) r_mem[r_wr_ptr] <= i_res.w0;
        if (i_res.v1) r_mem[wr_ptr1]  <= i_res.w1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
